// File: rtl/thermistor_adc_to_temperature_core_defines.svh
// Assertion macros used by the thermistor conversion core.
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CORE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define TADC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define TADC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tadc_pkg.sv
package tadc_pkg;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_OPEN  = 3'd2,
		ST_BELOW = 3'd3,
		ST_ABOVE = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SRCH,
		S_FETCH,
		S_FETCH2,
		S_DIV,
		S_OUT
	} state_t;

	typedef enum logic {
		REG_SHORT = 1'b0,
		REG_OPEN  = 1'b1
	} reg_idx_t;

	localparam int unsigned CURVE_W = 12;
	localparam int unsigned CURVE_OFFSET = 20;
	localparam int unsigned TENTHS = 10;
	localparam int unsigned CURVE_LEN = 141;

	localparam logic [CURVE_W-1:0] CURVE [CURVE_LEN] = '{
		12'd387, 12'd407, 12'd429, 12'd451, 12'd474, 12'd498, 12'd523, 12'd549,
		12'd575, 12'd603, 12'd631, 12'd660, 12'd691, 12'd722, 12'd754, 12'd787,
		12'd820, 12'd855, 12'd890, 12'd927, 12'd964, 12'd1002, 12'd1040, 12'd1079,
		12'd1119, 12'd1160, 12'd1201, 12'd1244, 12'd1286, 12'd1329, 12'd1373,
		12'd1417, 12'd1461, 12'd1506, 12'd1551, 12'd1596, 12'd1641, 12'd1686,
		12'd1732, 12'd1777, 12'd1823, 12'd1868, 12'd1913, 12'd1958, 12'd2003,
		12'd2048, 12'd2093, 12'd2137, 12'd2181, 12'd2225, 12'd2269, 12'd2312,
		12'd2354, 12'd2396, 12'd2438, 12'd2479, 12'd2519, 12'd2559, 12'd2598,
		12'd2636, 12'd2674, 12'd2711, 12'd2748, 12'd2784, 12'd2819, 12'd2853,
		12'd2887, 12'd2920, 12'd2952, 12'd2984, 12'd3014, 12'd3044, 12'd3074,
		12'd3102, 12'd3130, 12'd3157, 12'd3184, 12'd3209, 12'd3235, 12'd3259,
		12'd3283, 12'd3306, 12'd3329, 12'd3351, 12'd3372, 12'd3393, 12'd3413,
		12'd3433, 12'd3452, 12'd3470, 12'd3488, 12'd3506, 12'd3523, 12'd3540,
		12'd3556, 12'd3571, 12'd3587, 12'd3601, 12'd3616, 12'd3629, 12'd3643,
		12'd3656, 12'd3668, 12'd3681, 12'd3693, 12'd3704, 12'd3715, 12'd3726,
		12'd3736, 12'd3746, 12'd3756, 12'd3766, 12'd3775, 12'd3784, 12'd3793,
		12'd3801, 12'd3809, 12'd3817, 12'd3825, 12'd3832, 12'd3839, 12'd3846,
		12'd3853, 12'd3860, 12'd3866, 12'd3872, 12'd3878, 12'd3884, 12'd3890,
		12'd3895, 12'd3901, 12'd3906, 12'd3911, 12'd3916, 12'd3920, 12'd3925,
		12'd3929, 12'd3934, 12'd3938, 12'd3942, 12'd3946
	};

endpackage

// File: rtl/thermistor_adc_to_temperature_core.sv
// Thermistor ADC reading to temperature in tenths of a degree C.
// Input channel: adc_value with in_valid/in_ready. Output channel: status and
// temperature with out_valid/out_ready. One result per reading.
// Registers via cfg_we/cfg_index/cfg_data: 0 short threshold, 1 open threshold.
// Threshold and curve-end checks decide faults in the accept cycle. In-range
// readings binary search the curve ROM (registered read), fetch the
// bracketing pair, then a restoring divider loads the span and yields the
// tenths fraction one bit a cycle. out_valid rises in the cycle after a
// fault transfer, and after the search, fetch and divide states for an
// in-range transfer; one reading is in flight at a time, so a new reading
// is taken only after the result has transferred and the controller is
// back in idle. The curve ROM read port sets the search length.
// Reset clears thresholds to 15 and 4096, the held temperature to zero and
// returns the controller to idle. While the receiver stalls, the result
// holds on the output and no new reading is taken.
`include "thermistor_adc_to_temperature_core_defines.svh"

module thermistor_adc_to_temperature_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [11:0] adc_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic signed [11:0] temperature,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int unsigned TABLE_ENTRIES = tadc_pkg::CURVE_LEN;
	localparam int unsigned IW = $clog2(TABLE_ENTRIES);

	tadc_pkg::state_t state_q, state_d;
	logic [11:0] short_q;
	logic [12:0] open_q;
	logic [11:0] held_q;
	logic [11:0] v_q;
	logic [IW-1:0] l_q, r_q;
	logic [IW-1:0] addr;
	logic [11:0] rdata;
	logic [11:0] tl_q;
	logic [11:0] span_q;
	logic [15:0] num_q;
	logic [3:0] quo_q;
	logic [2:0] cnt_q;
	logic [2:0] status_q;
	logic [IW-1:0] mid;
	logic [IW:0] sum_lr;
	logic [11:0] curve_lo, curve_hi;
	logic [2:0] fault;
	logic [15:0] dvs;
	logic [16:0] trial;
	logic [11:0] base_l;

	assign curve_lo = tadc_pkg::CURVE[0];
	assign curve_hi = tadc_pkg::CURVE[TABLE_ENTRIES-1];
	assign sum_lr = {1'b0, l_q} + {1'b0, r_q};
	assign mid = sum_lr[IW:1];

	// Classify faults on the incoming reading
	always_comb begin
		if (adc_value <= short_q) begin
			fault = tadc_pkg::ST_SHORT;
		end else if ({1'b0, adc_value} >= open_q) begin
			fault = tadc_pkg::ST_OPEN;
		end else if (adc_value < curve_lo) begin
			fault = tadc_pkg::ST_BELOW;
		end else if (adc_value > curve_hi) begin
			fault = tadc_pkg::ST_ABOVE;
		end else begin
			fault = tadc_pkg::ST_OK;
		end
	end

	assign in_ready = (state_q == tadc_pkg::S_IDLE);
	assign out_valid = (state_q == tadc_pkg::S_OUT);
	assign status = status_q;
	assign temperature = held_q;

	// Address the ROM: midpoint while searching, then l and r
	always_comb begin
		case (state_q)
			tadc_pkg::S_SRCH:   addr = mid;
			tadc_pkg::S_FETCH2: addr = r_q;
			default:            addr = l_q;
		endcase
	end

	tadc_rom #(.WIDTH(12), .DEPTH(TABLE_ENTRIES)) u_rom (
		.clk   (clk),
		.addr  (addr),
		.rdata (rdata)
	);

	// Align the divisor with the quotient bit under test
	always_comb begin
		case (cnt_q)
			3'd1:    dvs = {1'b0, span_q, 3'd0};
			3'd2:    dvs = {2'd0, span_q, 2'd0};
			3'd3:    dvs = {3'd0, span_q, 1'b0};
			default: dvs = {4'd0, span_q};
		endcase
	end

	assign trial = {1'b0, num_q} - {1'b0, dvs};
	assign base_l = 12'(32'(l_q) * tadc_pkg::TENTHS - tadc_pkg::CURVE_OFFSET * tadc_pkg::TENTHS);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tadc_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (fault == tadc_pkg::ST_OK) ? tadc_pkg::S_SRCH
						: tadc_pkg::S_OUT;
				end
			end
			tadc_pkg::S_SRCH: begin
				if (cnt_q[0] && (r_q - l_q <= IW'(2))) begin
					state_d = tadc_pkg::S_FETCH;
				end
				if (!cnt_q[0] && (r_q - l_q <= IW'(1))) begin
					state_d = tadc_pkg::S_FETCH;
				end
			end
			tadc_pkg::S_FETCH:  state_d = tadc_pkg::S_FETCH2;
			tadc_pkg::S_FETCH2: state_d = tadc_pkg::S_DIV;
			tadc_pkg::S_DIV:    if (cnt_q == 3'd4) state_d = tadc_pkg::S_OUT;
			tadc_pkg::S_OUT:    if (out_ready) state_d = tadc_pkg::S_IDLE;
			default:            state_d = tadc_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tadc_pkg::S_IDLE;
			short_q <= 12'd15;
			open_q <= 13'd4096;
			held_q <= '0;
			status_q <= tadc_pkg::ST_OK;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			// Write configuration registers
			if (cfg_we) begin
				if (cfg_index == tadc_pkg::REG_SHORT) short_q <= cfg_data[11:0];
				else open_q <= cfg_data;
			end
			case (state_q)
				tadc_pkg::S_IDLE: begin
					status_q <= fault;
					cnt_q <= '0;
				end
				tadc_pkg::S_SRCH:  cnt_q <= cnt_q + 3'd1;
				tadc_pkg::S_FETCH2: cnt_q <= '0;
				tadc_pkg::S_DIV: begin
					cnt_q <= cnt_q + 3'd1;
					// Load the held value once the last quotient bit is in
					if (cnt_q == 3'd4) begin
						if (v_q == tl_q || span_q == '0) begin
							held_q <= base_l;
						end else begin
							held_q <= base_l + 12'({quo_q[2:0], !trial[16]});
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath: search bounds, bracket values and division
	always_ff @(posedge clk) begin
		case (state_q)
			tadc_pkg::S_IDLE: begin
				v_q <= adc_value;
				l_q <= '0;
				r_q <= IW'(TABLE_ENTRIES - 1);
			end
			tadc_pkg::S_SRCH: begin
				// Odd cycle: ROM holds curve[mid] of the previous cycle
				if (cnt_q[0]) begin
					if (v_q > rdata) l_q <= mid;
					else r_q <= mid;
				end
			end
			tadc_pkg::S_FETCH: ;
			tadc_pkg::S_FETCH2: begin
				// rdata holds curve[l]; r is read now and lands in DIV 0
				tl_q <= rdata;
				num_q <= 16'(32'(v_q - rdata) * tadc_pkg::TENTHS);
				quo_q <= '0;
			end
			tadc_pkg::S_DIV: begin
				if (cnt_q == 3'd0) begin
					span_q <= rdata - tl_q;
				end
				if (cnt_q != 3'd0) begin
					if (!trial[16]) num_q <= trial[15:0];
					quo_q <= {quo_q[2:0], !trial[16]};
				end
			end
			default: ;
		endcase
	end

	`TADC_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid, "ready while result pending")
	`TADC_ASSERT_NEXT(a_fault_hold, clk, arst_n, in_valid && in_ready && fault != tadc_pkg::ST_OK, out_valid && temperature == $past(temperature), "fault changed temperature")
	`TADC_ASSERT_NEXT(a_stall, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status), "result dropped on stall")

endmodule

// File: rtl/tadc_rom.sv
// Curve store: constant table with a registered read port.
module tadc_rom #(
	parameter int unsigned WIDTH = 12,
	parameter int unsigned DEPTH = 141
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic [WIDTH-1:0]         rdata
);

	// Register the read of the selected entry
	always_ff @(posedge clk) begin
		if (32'(addr) < tadc_pkg::CURVE_LEN) begin
			rdata <= WIDTH'(tadc_pkg::CURVE[addr]);
		end else begin
			rdata <= '0;
		end
	end

endmodule
